// ===== hdl/wrms_pkg.sv =====
// ----------------------------------------------------------------------------
// wrms_pkg
// Shared widths, register indexes, reset values and types of the windowed
// rms current meter.
// ----------------------------------------------------------------------------
`default_nettype none

package wrms_pkg;

  // default geometry
  localparam int unsigned DEF_SAMPLE_BITS = 12;
  localparam int unsigned DEF_COUNT_BITS  = 16;

  // datapath widths
  localparam int unsigned SUM_W    = 40;
  localparam int unsigned MEAN_W   = SUM_W + 16;
  localparam int unsigned ROOT_W   = MEAN_W / 2;
  localparam int unsigned RMS_W    = 20;
  localparam int unsigned MA_W     = 20;
  localparam int unsigned PWR_W    = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned LINE_W   = 10;
  localparam int unsigned CFG_IDX_W = 3;

  // current scale: 10000 / 256 reduced to 625 / 16
  localparam int unsigned SCALE_NUM   = 625;
  localparam int unsigned SCALE_NUM_W = 10;
  localparam int unsigned SCALE_SHIFT = 4;
  localparam int unsigned PROD_W      = RMS_W + CFG_W;
  localparam int unsigned NUM_W       = PROD_W + SCALE_NUM_W;

  localparam logic [RMS_W-1:0] RMS_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPLY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LINE      = 3'd5;

  // register reset values
  localparam logic [CFG_W-1:0]  RST_WINDOW    = 16'd4000;
  localparam logic [CFG_W-1:0]  RST_SUPPLY    = 16'd3300;
  localparam logic [CFG_W-1:0]  RST_SENS      = 16'd125;
  localparam logic [CFG_W-1:0]  RST_OFFSET    = 16'd2000;
  localparam logic [CFG_W-1:0]  RST_THRESHOLD = 16'd500;
  localparam logic [LINE_W-1:0] RST_LINE      = 10'd240;

  typedef struct packed {
    logic [CFG_W-1:0]  window_length;
    logic [CFG_W-1:0]  supply_millivolts;
    logic [CFG_W-1:0]  sensitivity_tenth_mv_per_amp;
    logic [CFG_W-1:0]  offset_milliamps;
    logic [CFG_W-1:0]  zero_threshold_milliamps;
    logic [LINE_W-1:0] line_volts;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/wrms_sample_if.sv =====
// ----------------------------------------------------------------------------
// wrms_sample_if
// Input channel: one pair of adc samples per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrms_sample_if import wrms_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] current_sample;
  logic [SAMPLE_BITS-1:0] reference_sample;

  modport source (output valid, output current_sample, output reference_sample,
                  input ready);
  modport sink   (input valid, input current_sample, input reference_sample,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/wrms_result_if.sv =====
// ----------------------------------------------------------------------------
// wrms_result_if
// Result channel: rms value, current and power of one window.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrms_result_if import wrms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RMS_W-1:0] rms_counts;
  logic [MA_W-1:0]  rms_milliamps;
  logic [PWR_W-1:0] power_milliwatts;

  modport source (output valid, output rms_counts, output rms_milliamps,
                  output power_milliwatts, input ready);
  modport sink   (input valid, input rms_counts, input rms_milliamps,
                  input power_milliwatts, output ready);
endinterface

`default_nettype wire

// ===== hdl/wrms_fifo.sv =====
// ----------------------------------------------------------------------------
// wrms_fifo
// Small register queue carrying closed windows from the front to the back.
// ----------------------------------------------------------------------------
`default_nettype none

module wrms_fifo import wrms_pkg::*; #(
  parameter int unsigned WIDTH = SUM_W + DEF_COUNT_BITS,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] pop_data_o,
  output logic                  empty_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CNT_W'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wrms_front.sv =====
// ----------------------------------------------------------------------------
// wrms_front
// Takes sample pairs, squares the difference and accumulates the window;
// pushes the closed sum and sample count into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wrms_front import wrms_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned COUNT_BITS  = DEF_COUNT_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  wrms_sample_if.sink                      sample_i,
  input  wire logic [CFG_W-1:0]            window_i,
  output logic                             push_o,
  output logic [SUM_W+COUNT_BITS-1:0]      push_data_o,
  input  wire logic                        full_i
);
  localparam int unsigned SQ_W = 2 * SAMPLE_BITS;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [31:0] CountMax32 = 32'(CountMax);

  logic [SAMPLE_BITS-1:0] mag;
  logic [SQ_W-1:0]        sq;
  logic                   s1_valid_q, s1_valid_d;
  logic [SQ_W-1:0]        s1_sq_q;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [COUNT_BITS-1:0]  count_q, count_d;
  logic [SUM_W:0]         sum_wide;
  logic [SUM_W-1:0]       sum_sat;
  logic [COUNT_BITS-1:0]  count_inc;
  logic [31:0]            win32;
  logic                   end_hit;
  logic                   s2_take;
  logic                   accept;

  // stage 1: magnitude of the difference and its square
  always_comb begin
    if (sample_i.current_sample >= sample_i.reference_sample) begin
      mag = sample_i.current_sample - sample_i.reference_sample;
    end else begin
      mag = sample_i.reference_sample - sample_i.current_sample;
    end
    sq = SQ_W'(mag) * SQ_W'(mag);
  end

  // stage 2: saturating accumulate, count and window check
  always_comb begin
    sum_wide  = {1'b0, sum_q} + (SUM_W + 1)'(s1_sq_q);
    sum_sat   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    count_inc = (count_q == CountMax) ? count_q : count_q + 1'b1;
    win32     = 32'(window_i);
    if (win32 == '0) begin
      win32 = 32'd1;
    end
    if (win32 > CountMax32) begin
      win32 = CountMax32;
    end
    end_hit = (32'(count_inc) >= win32);
  end

  assign s2_take        = !(s1_valid_q && end_hit && full_i);
  assign sample_i.ready = !s1_valid_q || s2_take;
  assign accept         = sample_i.valid && sample_i.ready;
  assign push_o         = s1_valid_q && end_hit && !full_i;
  assign push_data_o    = {sum_sat, count_inc};

  // next state of both stages
  always_comb begin
    s1_valid_d = s1_valid_q;
    sum_d      = sum_q;
    count_d    = count_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s2_take) begin
      s1_valid_d = 1'b0;
    end
    if (s1_valid_q && s2_take) begin
      if (end_hit) begin
        sum_d   = '0;
        count_d = '0;
      end else begin
        sum_d   = sum_sat;
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      sum_q      <= '0;
      count_q    <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      sum_q      <= sum_d;
      count_q    <= count_d;
    end
  end

  // square register, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sq_q <= sq;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wrms_div.sv =====
// ----------------------------------------------------------------------------
// wrms_div
// Restoring divider, one quotient bit per cycle, shared by the mean and the
// current scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module wrms_div import wrms_pkg::*; #(
  parameter int unsigned DN_W = MEAN_W,
  parameter int unsigned DV_W = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DN_W-1:0] dividend_i,
  input  wire logic [DV_W-1:0] divisor_i,
  output logic                 done_o,
  output logic      [DN_W-1:0] quot_o
);
  localparam int unsigned CNT_W = $clog2(DN_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DN_W-1:0]  quo_q, quo_d;
  logic [DV_W-1:0]  rem_q, rem_d;
  logic [DV_W-1:0]  dv_q, dv_d;
  logic [DV_W:0]    rem_sh;
  logic             ge;

  assign done_o = done_q;
  assign quot_o = quo_q;

  // one shift-subtract step
  always_comb begin
    rem_sh = {rem_q, quo_q[DN_W-1]};
    ge     = (rem_sh >= {1'b0, dv_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DN_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dv_d   = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DN_W-2:0], ge};
      rem_d = ge ? DV_W'(rem_sh - {1'b0, dv_q}) : rem_sh[DV_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
  end

endmodule

`default_nettype wire

// ===== hdl/wrms_back.sv =====
// ----------------------------------------------------------------------------
// wrms_back
// Window-end math: mean by division, square root, current scaling, offset,
// threshold and power, then the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wrms_back import wrms_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned COUNT_BITS  = DEF_COUNT_BITS,
  parameter int unsigned DEN_W       = DEF_SAMPLE_BITS + CFG_W + SCALE_SHIFT,
  parameter int unsigned DV_W        = DEF_SAMPLE_BITS + CFG_W + SCALE_SHIFT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cfg_t                         cfg_i,
  input  wire logic                         q_empty_i,
  input  wire logic [SUM_W+COUNT_BITS-1:0]  q_data_i,
  output logic                              q_pop_o,
  wrms_result_if.source                     result_o
);
  localparam int unsigned SQ_CNT_W = $clog2(ROOT_W);
  localparam logic [SAMPLE_BITS-1:0] FullScale = '1;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIVM = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_MUL1 = 3'd3;
  localparam logic [2:0] ST_MUL2 = 3'd4;
  localparam logic [2:0] ST_DIVC = 3'd5;
  localparam logic [2:0] ST_CUR  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [MEAN_W-1:0]   sq_rad_q, sq_rad_d;
  logic [ROOT_W+1:0]   sq_rem_q, sq_rem_d;
  logic [ROOT_W-1:0]   sq_root_q, sq_root_d;
  logic [SQ_CNT_W-1:0] sq_cnt_q, sq_cnt_d;
  logic [ROOT_W+1:0]   rem_sh;
  logic [ROOT_W+1:0]   trial;
  logic                sq_ge;
  logic [RMS_W-1:0]    rms_q, rms_d;
  logic [RMS_W-1:0]    rms_sat;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [DEN_W-1:0]    den_q, den_d;
  logic [CFG_W-1:0]    sens_eff;
  logic [NUM_W-1:0]    num;
  logic [MA_W-1:0]     cur_q, cur_d;
  logic [MEAN_W-1:0]   raw_diff;
  logic                out_valid_q, out_valid_d;
  logic [RMS_W-1:0]    out_rms_q;
  logic [MA_W-1:0]     out_ma_q;
  logic [PWR_W-1:0]    out_pwr_q;
  logic                out_load;
  logic                div_start;
  logic [MEAN_W-1:0]   div_dividend;
  logic [DV_W-1:0]     div_divisor;
  logic                div_done;
  logic [MEAN_W-1:0]   div_quot;

  wrms_div #(
    .DN_W (MEAN_W),
    .DV_W (DV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // square root digit step, two radicand bits per cycle
  always_comb begin
    rem_sh = {sq_rem_q[ROOT_W-1:0], sq_rad_q[MEAN_W-1 -: 2]};
    trial  = {sq_root_q, 2'b01};
    sq_ge  = (rem_sh >= trial);
  end

  // scaling products
  always_comb begin
    rms_sat  = (sq_root_q > ROOT_W'(RMS_MAX)) ? RMS_MAX : sq_root_q[RMS_W-1:0];
    sens_eff = (cfg_i.sensitivity_tenth_mv_per_amp == '0) ? CFG_W'(1)
                                                         : cfg_i.sensitivity_tenth_mv_per_amp;
    num      = NUM_W'(prod_q) * NUM_W'(SCALE_NUM);
    raw_diff = div_quot - MEAN_W'(cfg_i.offset_milliamps);
  end

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || result_o.ready);
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;

  // sequencer
  always_comb begin
    state_d      = state_q;
    sq_rad_d     = sq_rad_q;
    sq_rem_d     = sq_rem_q;
    sq_root_d    = sq_root_q;
    sq_cnt_d     = sq_cnt_q;
    rms_d        = rms_q;
    prod_d       = prod_q;
    den_d        = den_q;
    cur_d        = cur_q;
    div_start    = 1'b0;
    div_dividend = {q_data_i[SUM_W+COUNT_BITS-1:COUNT_BITS], 16'h0000};
    div_divisor  = DV_W'(q_data_i[COUNT_BITS-1:0]);
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          div_start = 1'b1;
          state_d   = ST_DIVM;
        end
      end
      ST_DIVM: begin
        if (div_done) begin
          sq_rad_d  = div_quot;
          sq_rem_d  = '0;
          sq_root_d = '0;
          sq_cnt_d  = '0;
          state_d   = ST_SQRT;
        end
      end
      ST_SQRT: begin
        sq_rad_d  = {sq_rad_q[MEAN_W-3:0], 2'b00};
        sq_rem_d  = sq_ge ? rem_sh - trial : rem_sh;
        sq_root_d = {sq_root_q[ROOT_W-2:0], sq_ge};
        sq_cnt_d  = sq_cnt_q + 1'b1;
        if (sq_cnt_q == SQ_CNT_W'(ROOT_W - 1)) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        rms_d   = rms_sat;
        prod_d  = PROD_W'(rms_sat) * PROD_W'(cfg_i.supply_millivolts);
        den_d   = DEN_W'((DEN_W'(FullScale) * DEN_W'(sens_eff)) << SCALE_SHIFT);
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        div_start    = 1'b1;
        div_dividend = MEAN_W'(num);
        div_divisor  = DV_W'(den_q);
        state_d      = ST_DIVC;
      end
      ST_DIVC: begin
        if (div_done) begin
          state_d = ST_CUR;
        end
      end
      ST_CUR: begin
        if (div_quot <= MEAN_W'(cfg_i.offset_milliamps)) begin
          cur_d = '0;
        end else if (raw_diff <= MEAN_W'(cfg_i.zero_threshold_milliamps)) begin
          cur_d = '0;
        end else if (raw_diff > MEAN_W'(RMS_MAX)) begin
          cur_d = RMS_MAX;
        end else begin
          cur_d = raw_diff[MA_W-1:0];
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.rms_counts       = out_rms_q;
  assign result_o.rms_milliamps    = out_ma_q;
  assign result_o.power_milliwatts = out_pwr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    sq_rad_q  <= sq_rad_d;
    sq_rem_q  <= sq_rem_d;
    sq_root_q <= sq_root_d;
    sq_cnt_q  <= sq_cnt_d;
    rms_q     <= rms_d;
    prod_q    <= prod_d;
    den_q     <= den_d;
    cur_q     <= cur_d;
    if (out_load) begin
      out_rms_q <= rms_q;
      out_ma_q  <= cur_q;
      out_pwr_q <= PWR_W'(cur_q) * PWR_W'(cfg_i.line_volts);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/windowed_rms_current_meter_unit.sv =====
// ----------------------------------------------------------------------------
// windowed_rms_current_meter_unit
// Windowed rms meter: sums squared sample differences over a window and
// reports rms counts, current in milliamps and power in milliwatts.
// ----------------------------------------------------------------------------
// Usage
//   sample_i carries one pair of adc samples per item (valid/ready); the
//   front takes one item per cycle unless a closed window waits on a full
//   queue, squares it as it is taken, registers the square and then adds
//   it to the sum. result_o carries one item per closed window. The back
//   computes each result with a restoring divider used twice and a square
//   root. A two-entry queue holds closed windows; the back takes the next
//   window from it only once the last result is in the output register,
//   so short windows can fill the queue and stall the input.
//   When the receiver stalls, the finished result waits in the output
//   register while the back works on the next window; the queue and then
//   the input stall only once those are full.
//   Reset clears the sum, the count, the queue and the output, and loads
//   the register defaults. Registers are written through cfg_we_i,
//   cfg_idx_i and cfg_wdata_i; the user must write them only while no
//   window is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_rms_current_meter_unit import wrms_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned COUNT_BITS  = DEF_COUNT_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  wrms_sample_if.sink               sample_i,
  wrms_result_if.source             result_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);
  localparam int unsigned Q_W   = SUM_W + COUNT_BITS;
  localparam int unsigned DEN_W = SAMPLE_BITS + CFG_W + SCALE_SHIFT;
  localparam int unsigned DV_W  = (DEN_W > COUNT_BITS) ? DEN_W : COUNT_BITS;

  cfg_t           cfg_q, cfg_d;
  logic           q_push;
  logic [Q_W-1:0] q_push_data;
  logic           q_full;
  logic           q_pop;
  logic [Q_W-1:0] q_pop_data;
  logic           q_empty;

  // register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW:    cfg_d.window_length                = cfg_wdata_i;
        REG_SUPPLY:    cfg_d.supply_millivolts            = cfg_wdata_i;
        REG_SENS:      cfg_d.sensitivity_tenth_mv_per_amp = cfg_wdata_i;
        REG_OFFSET:    cfg_d.offset_milliamps             = cfg_wdata_i;
        REG_THRESHOLD: cfg_d.zero_threshold_milliamps     = cfg_wdata_i;
        REG_LINE:      cfg_d.line_volts                   = cfg_wdata_i[LINE_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length                <= RST_WINDOW;
      cfg_q.supply_millivolts            <= RST_SUPPLY;
      cfg_q.sensitivity_tenth_mv_per_amp <= RST_SENS;
      cfg_q.offset_milliamps             <= RST_OFFSET;
      cfg_q.zero_threshold_milliamps     <= RST_THRESHOLD;
      cfg_q.line_volts                   <= RST_LINE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // accumulating front
  wrms_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i),
    .window_i    (cfg_q.window_length),
    .push_o      (q_push),
    .push_data_o (q_push_data),
    .full_i      (q_full)
  );

  // closed-window queue
  wrms_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .empty_o     (q_empty)
  );

  // window-end math
  wrms_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .DEN_W       (DEN_W),
    .DV_W        (DV_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_data_i  (q_pop_data),
    .q_pop_o   (q_pop),
    .result_o  (result_o)
  );

  // queue never written when full
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("window queue overflow");

  // queue never read when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("window queue underflow");

  // zero current gives zero power
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.rms_milliamps == '0)) |->
      (result_o.power_milliwatts == '0))
    else $error("power without current");

endmodule

`default_nettype wire

// ===== dv/windowed_rms_current_meter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_rms_current_meter_unit_tb
// Self-checking bench for the windowed rms current meter. Streams sample
// pairs through the valid/ready channel under random backpressure, keeps a
// bit-exact model of the square sum, the window count and the current and
// power scaling, and compares every result item against it in order.
// ----------------------------------------------------------------------------

module windowed_rms_current_meter_unit_tb;
  import wrms_pkg::*;

  localparam int unsigned SMP_W              = DEF_SAMPLE_BITS;
  localparam int unsigned CNT_W              = DEF_COUNT_BITS;
  localparam int unsigned RESET_CYCLES       = 9;
  localparam int unsigned CYCLE_LIMIT        = 1_500_000;
  localparam int unsigned SETTLE_CYCLES      = 400;
  localparam int unsigned RANDOM_ITEMS       = 570;
  localparam int unsigned DEFAULT_ITEMS      = 120;
  localparam int unsigned LONG_WINDOW        = 256;

  localparam longint unsigned FULL_SCALE = (longint'(1) << SMP_W) - 1;
  localparam longint unsigned SUM_LIMIT  = (longint'(1) << SUM_W) - 1;
  localparam longint unsigned CNT_LIMIT  = (longint'(1) << CNT_W) - 1;
  localparam longint unsigned MA_LIMIT   = (longint'(1) << MA_W) - 1;
  localparam longint unsigned PWR_LIMIT  = (longint'(1) << PWR_W) - 1;
  localparam longint unsigned MA_SCALE   = 10000;
  localparam longint unsigned FRAC_SCALE = 256;
  localparam logic [SMP_W-1:0] SMP_TOP   = '1;

  typedef struct packed {
    logic [RMS_W-1:0] rms_counts;
    logic [MA_W-1:0]  rms_milliamps;
    logic [PWR_W-1:0] power_milliwatts;
  } meter_reading_t;

  // sample shapes used by the random phases
  typedef enum int unsigned {MIX_UNIFORM, MIX_NEAR, MIX_RAILS, MIX_WAVE} pair_mix_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  wrms_sample_if #(.SAMPLE_BITS(SMP_W)) smp ();
  wrms_result_if res ();

  windowed_rms_current_meter_unit #(
    .SAMPLE_BITS(SMP_W),
    .COUNT_BITS (CNT_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (smp),
    .result_o   (res),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // model state and register copies
  cfg_t            meter_cfg;
  longint unsigned sq_sum;
  longint unsigned n_samples;
  meter_reading_t  pending_readings[$];

  int unsigned err_count    = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count  = 0;
  bit          steady       = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // bit-by-bit floor square root
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (longint'(1) << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // fold one sample pair into the window; returns 1 when the window closes
  function automatic bit accumulate_pair(input logic [SMP_W-1:0] cur_s,
                                         input logic [SMP_W-1:0] ref_s,
                                         output meter_reading_t rd);
    longint unsigned mag, sq, win, mean, root, sens, raw, amps, watts;
    rd = '0;
    mag = (cur_s >= ref_s) ? cur_s - ref_s : ref_s - cur_s;
    sq = mag * mag;
    if (sq > SUM_LIMIT - sq_sum) sq_sum = SUM_LIMIT;
    else sq_sum = sq_sum + sq;
    if (n_samples < CNT_LIMIT) n_samples++;

    // zero window acts as one, windows past the counter end at its top
    win = meter_cfg.window_length;
    if (win == 0) win = 1;
    if (win > CNT_LIMIT) win = CNT_LIMIT;
    if (n_samples < win) return 1'b0;

    mean = (sq_sum << 16) / n_samples;
    root = floor_sqrt(mean);
    if (root > RMS_MAX) root = RMS_MAX;

    sens = meter_cfg.sensitivity_tenth_mv_per_amp;
    if (sens == 0) sens = 1;
    raw = (root * meter_cfg.supply_millivolts * MA_SCALE) / (FULL_SCALE * sens * FRAC_SCALE);

    // offset removal, zero band, saturation
    if (raw <= meter_cfg.offset_milliamps) begin
      amps = 0;
    end else begin
      amps = raw - meter_cfg.offset_milliamps;
      if (amps <= meter_cfg.zero_threshold_milliamps) amps = 0;
      else if (amps > MA_LIMIT) amps = MA_LIMIT;
    end
    watts = amps * meter_cfg.line_volts;
    if (watts > PWR_LIMIT) watts = PWR_LIMIT;

    rd.rms_counts       = root[RMS_W-1:0];
    rd.rms_milliamps    = amps[MA_W-1:0];
    rd.power_milliwatts = watts[PWR_W-1:0];
    sq_sum    = 0;
    n_samples = 0;
    return 1'b1;
  endfunction

  // result checker
  initial begin
    meter_reading_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1) begin
        result_count++;
        if (pending_readings.size() == 0) begin
          $error("result item with no reading expected: rms_counts %0d", res.rms_counts);
          err_count++;
        end else begin
          want = pending_readings.pop_front();
          if (res.rms_counts !== want.rms_counts) begin
            $error("rms_counts: expected %0d, actual %0d", want.rms_counts, res.rms_counts);
            err_count++;
          end
          if (res.rms_milliamps !== want.rms_milliamps) begin
            $error("rms_milliamps: expected %0d, actual %0d",
                   want.rms_milliamps, res.rms_milliamps);
            err_count++;
          end
          if (res.power_milliwatts !== want.power_milliwatts) begin
            $error("power_milliwatts: expected %0d, actual %0d",
                   want.power_milliwatts, res.power_milliwatts);
            err_count++;
          end
        end
      end
    end
  end

  // result backpressure in random bursts
  initial begin
    int unsigned span;
    res.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (steady) begin
        res.ready <= 1'b1;
        span = 1;
      end else if ($urandom_range(0, 2) == 0) begin
        res.ready <= 1'b0;
        span = $urandom_range(1, 18);
      end else begin
        res.ready <= 1'b1;
        span = $urandom_range(1, 30);
      end
      repeat (span) @(posedge clk_i);
    end
  end

  // send one sample pair, with an occasional gap in front of it
  task automatic send_pair(input logic [SMP_W-1:0] cur_s, input logic [SMP_W-1:0] ref_s);
    meter_reading_t rd;
    bit taken;
    if (!steady && $urandom_range(0, 4) == 0) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    smp.valid            <= 1'b1;
    smp.current_sample   <= cur_s;
    smp.reference_sample <= ref_s;
    do begin
      @(negedge clk_i);
      taken = smp.ready;
      @(posedge clk_i);
    end while (!taken);
    if (accumulate_pair(cur_s, ref_s, rd)) pending_readings.push_back(rd);
  endtask

  // drain: all readings in, then let the back stage run dry
  task automatic settle();
    smp.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write; the caller drops the write enable afterwards
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_WINDOW:    meter_cfg.window_length = value;
      REG_SUPPLY:    meter_cfg.supply_millivolts = value;
      REG_SENS:      meter_cfg.sensitivity_tenth_mv_per_amp = value;
      REG_OFFSET:    meter_cfg.offset_milliamps = value;
      REG_THRESHOLD: meter_cfg.zero_threshold_milliamps = value;
      REG_LINE:      meter_cfg.line_volts = value[LINE_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input cfg_t c);
    put_reg(REG_WINDOW, c.window_length);
    put_reg(REG_SUPPLY, c.supply_millivolts);
    put_reg(REG_SENS, c.sensitivity_tenth_mv_per_amp);
    put_reg(REG_OFFSET, c.offset_milliamps);
    put_reg(REG_THRESHOLD, c.zero_threshold_milliamps);
    put_reg(REG_LINE, CFG_W'(c.line_volts));
    cfg_we_i <= 1'b0;
  endtask

  // register value: extremes now and then, otherwise full range or typical
  function automatic logic [CFG_W-1:0] pick_setting(input int unsigned top,
                                                    input int unsigned typ_hi);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return CFG_W'(0);
    if (roll == 1) return CFG_W'(top);
    if (roll < 5) return CFG_W'($urandom_range(0, top));
    return CFG_W'($urandom_range(1, typ_hi));
  endfunction

  // mostly short windows so results keep coming
  function automatic logic [CFG_W-1:0] pick_window();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return CFG_W'(0);
    if (roll < 7) return CFG_W'($urandom_range(1, 32));
    if (roll < 9) return CFG_W'($urandom_range(33, 200));
    return CFG_W'($urandom_range(201, 600));
  endfunction

  function automatic cfg_t pick_cfg();
    cfg_t c;
    c.window_length                = pick_window();
    c.supply_millivolts            = pick_setting(65535, 5000);
    c.sensitivity_tenth_mv_per_amp = pick_setting(65535, 400);
    c.offset_milliamps             = pick_setting(65535, 3000);
    c.zero_threshold_milliamps     = pick_setting(65535, 1000);
    c.line_volts                   = LINE_W'(pick_setting(1023, 1023));
    return c;
  endfunction

  // one pair of the given shape
  task automatic send_mixed(input pair_mix_e mix);
    logic [SMP_W-1:0] a, b;
    int tmp;
    a = SMP_W'($urandom);
    b = SMP_W'($urandom);
    case (mix)
      MIX_NEAR: begin
        tmp = int'(b) + int'($urandom_range(0, 16)) - 8;
        if (tmp < 0) tmp = 0;
        if (tmp > int'(FULL_SCALE)) tmp = int'(FULL_SCALE);
        a = SMP_W'(tmp);
      end
      MIX_RAILS: begin
        if ($urandom_range(0, 3) != 0) a = $urandom_range(0, 1) ? SMP_TOP : '0;
        if ($urandom_range(0, 3) != 0) b = $urandom_range(0, 1) ? SMP_TOP : '0;
      end
      MIX_WAVE: begin
        a = SMP_W'(2048 + $urandom_range(0, 4094) - 2047);
        b = SMP_W'(2048 + $urandom_range(0, 6) - 3);
      end
      default: ;
    endcase
    send_pair(a, b);
  endtask

  // reset register values; the reset window is cut short to close it
  task automatic test_default_window();
    repeat (DEFAULT_ITEMS) send_mixed(MIX_UNIFORM);
    settle();
    put_reg(REG_WINDOW, 16'd100);
    cfg_we_i <= 1'b0;
    send_mixed(MIX_UNIFORM);
  endtask

  // field extremes and alternating bit patterns, one result per item
  task automatic test_field_extremes();
    settle();
    put_reg(REG_WINDOW, 16'd1);
    cfg_we_i <= 1'b0;
    send_pair('0, '0);
    send_pair(SMP_TOP, '0);
    send_pair('0, SMP_TOP);
    send_pair(SMP_TOP, SMP_TOP);
    send_pair(12'd1, '0);
    send_pair(12'd2048, 12'd2047);
    send_pair(12'hAAA, 12'h555);
    send_pair(12'h555, 12'hAAA);
  endtask

  // zero window behaves as one sample
  task automatic test_window_zero();
    settle();
    put_reg(REG_WINDOW, 16'd0);
    cfg_we_i <= 1'b0;
    send_pair(12'd3000, 12'd100);
    send_pair(12'd100, 12'd3000);
    send_pair(12'd7, 12'd7);
  endtask

  // window shortened below the running count closes on the next item
  task automatic test_window_shortened();
    settle();
    put_reg(REG_WINDOW, 16'd9);
    cfg_we_i <= 1'b0;
    repeat (5) send_mixed(MIX_UNIFORM);
    settle();
    put_reg(REG_WINDOW, 16'd3);
    cfg_we_i <= 1'b0;
    send_mixed(MIX_UNIFORM);
  endtask

  // zero sensitivity, saturated current, zero band and offset extremes
  task automatic test_gain_and_offset();
    cfg_t c;
    settle();
    c = '{window_length: 16'd1, supply_millivolts: 16'd65535,
          sensitivity_tenth_mv_per_amp: 16'd0, offset_milliamps: 16'd0,
          zero_threshold_milliamps: 16'd0, line_volts: 10'd1023};
    apply_settings(c);
    send_pair(SMP_TOP, '0);
    send_pair('0, 12'd1);
    settle();
    c = '{window_length: 16'd1, supply_millivolts: 16'd3300,
          sensitivity_tenth_mv_per_amp: 16'd125, offset_milliamps: 16'd0,
          zero_threshold_milliamps: 16'd65535, line_volts: 10'd0};
    apply_settings(c);
    send_pair(SMP_TOP, '0);
    send_pair(12'd100, '0);
    settle();
    c = '{window_length: 16'd1, supply_millivolts: 16'd1,
          sensitivity_tenth_mv_per_amp: 16'd65535, offset_milliamps: 16'd65535,
          zero_threshold_milliamps: 16'd0, line_volts: 10'd1023};
    apply_settings(c);
    send_pair('0, SMP_TOP);
    send_pair(SMP_TOP, SMP_TOP);
  endtask

  // long window at full swing
  task automatic test_long_window();
    cfg_t c;
    settle();
    c = '{window_length: CFG_W'(LONG_WINDOW), supply_millivolts: 16'd3300,
          sensitivity_tenth_mv_per_amp: 16'd125, offset_milliamps: 16'd2000,
          zero_threshold_milliamps: 16'd500, line_volts: 10'd240};
    apply_settings(c);
    steady = 1'b1;
    for (int i = 0; i < int'(LONG_WINDOW); i++) begin
      if (i[0]) send_pair(SMP_TOP, '0);
      else send_pair('0, SMP_TOP);
    end
    steady = 1'b0;
  endtask

  // random settings per phase, random pairs of one shape per phase
  task automatic test_random_phases();
    int unsigned sent;
    int unsigned n_items;
    pair_mix_e mix;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      steady = ($urandom_range(0, 5) == 0);
      apply_settings(pick_cfg());
      mix = pair_mix_e'($urandom_range(0, 3));
      n_items = $urandom_range(10, 90);
      repeat (n_items) send_mixed(mix);
      sent += n_items;
    end
    steady = 1'b0;
  endtask

  // closing stretch with no idling on either side
  task automatic test_steady_tail();
    cfg_t c;
    settle();
    steady = 1'b1;
    c = pick_cfg();
    c.window_length = CFG_W'($urandom_range(1, 16));
    apply_settings(c);
    repeat (80) send_mixed(MIX_UNIFORM);
  endtask

  // main sequence
  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = REG_WINDOW;
    cfg_wdata_i          = '0;
    smp.valid            = 1'b0;
    smp.current_sample   = '0;
    smp.reference_sample = '0;

    meter_cfg.window_length                = RST_WINDOW;
    meter_cfg.supply_millivolts            = RST_SUPPLY;
    meter_cfg.sensitivity_tenth_mv_per_amp = RST_SENS;
    meter_cfg.offset_milliamps             = RST_OFFSET;
    meter_cfg.zero_threshold_milliamps     = RST_THRESHOLD;
    meter_cfg.line_volts                   = RST_LINE;
    sq_sum    = 0;
    n_samples = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_window();
    test_field_extremes();
    test_window_zero();
    test_window_shortened();
    test_gain_and_offset();
    test_long_window();
    test_random_phases();
    test_steady_tail();
    settle();

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
